// ===== sv/sabsf_pkg.sv =====
`default_nettype none
package sabsf_pkg;

    localparam int RESULT_BITS = 12;
    localparam int VOLT_W      = 16;
    localparam int WORD_W      = 16;
    localparam int DIV_CNT_W   = $clog2(RESULT_BITS);

    localparam logic [VOLT_W-1:0] REF_RESET = 16'd3300;

    // beat kinds
    localparam logic [1:0] KIND_SELECT   = 2'd0;
    localparam logic [1:0] KIND_CLOCK    = 2'd1;
    localparam logic [1:0] KIND_DESELECT = 2'd2;

    // frame counters
    localparam logic [1:0] BYTE_FIRST = 2'd0;
    localparam logic [1:0] BYTE_CMD   = 2'd1;
    localparam logic [1:0] BYTE_LAST  = 2'd2;
    localparam logic [1:0] BYTE_DONE  = 2'd3;
    localparam logic [2:0] POS_MSB    = 3'd7;
    localparam logic [2:0] POS_DECODE = 3'd5;
    localparam logic [2:0] POS_LSB    = 3'd0;

    // command byte 0 fields
    localparam int CMD_START_BIT = 2;
    localparam int CMD_SGL_BIT   = 1;
    localparam int CMD_CH_MSB    = 0;

    typedef struct packed {
        logic [1:0]        kind;
        logic              mosi_bit;
        logic [VOLT_W-1:0] ch0_voltage;
        logic [VOLT_W-1:0] ch1_voltage;
        logic [VOLT_W-1:0] ch2_voltage;
        logic [VOLT_W-1:0] ch3_voltage;
        logic [VOLT_W-1:0] ch4_voltage;
        logic [VOLT_W-1:0] ch5_voltage;
        logic [VOLT_W-1:0] ch6_voltage;
        logic [VOLT_W-1:0] ch7_voltage;
    } t_in_beat;

    typedef struct packed {
        logic miso_bit;
        logic converted;
    } t_out_beat;

    typedef struct packed {
        logic accept;
        logic div_step;
    } t_cmd;

    typedef struct packed {
        logic result;
        logic conv_start;
        logic div_last;
    } t_sts;

endpackage
`default_nettype wire

// ===== sv/sabsf_dpath.sv =====
`default_nettype none
module sabsf_dpath
    import sabsf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_in_beat          i_in,
    input  wire logic              i_cfg_we,
    input  wire logic [VOLT_W-1:0] i_cfg_data,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output t_out_beat              o_out
);

    logic [VOLT_W-1:0]      r_ref;
    logic                   r_selected;
    logic [1:0]             r_byte_count;
    logic [2:0]             r_bit_pos;
    logic [7:0]             r_cmd [2];
    logic [RESULT_BITS-1:0] r_reply;
    logic [DIV_CNT_W-1:0]   r_div_cnt;
    logic [VOLT_W-1:0]      r_rem;
    logic [VOLT_W-1:0]      r_div;
    t_out_beat              r_out;

    logic              is_edge;
    logic              decode_pt;
    logic              start_set;
    logic              sgl;
    logic              v_ge;
    logic              miso;
    logic [WORD_W-1:0] word;
    logic [7:0]        reply_byte;
    logic [7:0]        n_cmd;
    logic [2:0]        chan;
    logic [VOLT_W-1:0] volt;
    logic [VOLT_W+1:0] trial;

    always_comb begin
        is_edge = (i_in.kind == KIND_CLOCK) && r_selected && (r_byte_count != BYTE_DONE);
        word    = WORD_W'(r_reply);
        case (r_byte_count)
            BYTE_CMD:  reply_byte = word[15:8];
            BYTE_LAST: reply_byte = word[7:0];
            default:   reply_byte = 8'h00;
        endcase
        miso = reply_byte[r_bit_pos];

        n_cmd = ((r_bit_pos == POS_MSB) ? 8'h00 : r_cmd[r_byte_count[0]])
              | (8'(i_in.mosi_bit) << r_bit_pos);

        decode_pt = is_edge && (r_byte_count == BYTE_CMD) && (r_bit_pos == POS_DECODE);
        start_set = r_cmd[0][CMD_START_BIT];
        sgl       = r_cmd[0][CMD_SGL_BIT];
        chan      = {r_cmd[0][CMD_CH_MSB], n_cmd[7:6]};
        case (chan)
            3'd0:    volt = i_in.ch0_voltage;
            3'd1:    volt = i_in.ch1_voltage;
            3'd2:    volt = i_in.ch2_voltage;
            3'd3:    volt = i_in.ch3_voltage;
            3'd4:    volt = i_in.ch4_voltage;
            3'd5:    volt = i_in.ch5_voltage;
            3'd6:    volt = i_in.ch6_voltage;
            default: volt = i_in.ch7_voltage;
        endcase
        // v >= vref means the quotient overflows full scale (also vref of zero)
        v_ge = (volt >= r_ref);

        // one restoring step: remainder always stays below the divisor
        trial = {1'b0, r_rem, 1'b0} - {2'b00, r_div};

        o_sts.result     = is_edge;
        o_sts.conv_start = decode_pt && start_set && sgl && !v_ge;
        o_sts.div_last   = (r_div_cnt == DIV_CNT_W'(RESULT_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref        <= REF_RESET;
            r_selected   <= 1'b0;
            r_byte_count <= BYTE_FIRST;
            r_bit_pos    <= POS_MSB;
            r_cmd[0]     <= 8'h00;
            r_cmd[1]     <= 8'h00;
            r_reply      <= '0;
            r_div_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_ref <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                case (i_in.kind)
                    KIND_SELECT: begin
                        if (!r_selected) begin
                            r_byte_count <= BYTE_FIRST;
                            r_bit_pos    <= POS_MSB;
                        end
                        r_selected <= 1'b1;
                    end
                    KIND_DESELECT: begin
                        r_selected <= 1'b0;
                    end
                    KIND_CLOCK: begin
                        if (is_edge) begin
                            if (r_byte_count != BYTE_LAST) begin
                                r_cmd[r_byte_count[0]] <= n_cmd;
                            end
                            if (r_bit_pos == POS_LSB) begin
                                r_bit_pos    <= POS_MSB;
                                r_byte_count <= r_byte_count + 2'd1;
                            end else begin
                                r_bit_pos <= r_bit_pos - 3'd1;
                            end
                            if (r_byte_count == BYTE_FIRST && r_bit_pos == POS_MSB) begin
                                r_reply <= '0;
                            end
                            if (decode_pt && start_set) begin
                                if (!sgl) begin
                                    r_reply <= '0;
                                end else if (v_ge) begin
                                    r_reply <= '1;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
                if (o_sts.conv_start) begin
                    r_div_cnt <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_reply   <= {r_reply[RESULT_BITS-2:0], ~trial[VOLT_W+1]};
                r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && o_sts.conv_start) begin
            r_rem <= volt;
            r_div <= r_ref;
        end else if (i_cmd.div_step) begin
            r_rem <= trial[VOLT_W+1] ? {r_rem[VOLT_W-2:0], 1'b0} : trial[VOLT_W-1:0];
        end
        if (i_cmd.accept && o_sts.result) begin
            r_out.miso_bit  <= miso;
            r_out.converted <= decode_pt && start_set;
        end
    end

    assign o_out = r_out;

    a_done_at_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count == BYTE_DONE |-> r_bit_pos == POS_MSB)
        else $error("frame complete with bit position not at msb");

    a_div_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> r_div_cnt <= DIV_CNT_W'(RESULT_BITS - 1))
        else $error("divider stepped past its last quotient bit");

endmodule
`default_nettype wire

// ===== sv/sabsf_ctrl.sv =====
`default_nettype none
module sabsf_ctrl
    import sabsf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_in_ready     = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
        o_cmd.accept   = i_in_valid && o_in_ready;
        o_cmd.div_step = (r_state == ST_DIV);

        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_cmd.accept && i_sts.conv_start) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        // output register drains on a taken beat, refills on a result
        if (o_cmd.accept && i_sts.result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_no_accept_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_step |-> !o_cmd.accept)
        else $error("beat accepted while divider busy");

    a_start_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept && i_sts.conv_start |=> r_state == ST_DIV)
        else $error("conversion start did not enter divide");

    a_end_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV && i_sts.div_last |=> r_state == ST_IDLE)
        else $error("divider did not release after last step");

endmodule
`default_nettype wire

// ===== sv/spi_adc_12bit_bit_serial_frame_top.sv =====
// Serial side of an eight-channel 12-bit converter, one SPI event per input beat.
// Input channel (i_in_valid / o_in_ready, payload i_in): kind selects chip-select
// fall, serial clock rise or deselect; mosi_bit and the eight channel voltages
// (millivolts) travel with every beat.
// Output channel (o_out_valid / i_out_ready, payload o_out): one beat per clock
// edge shifted inside a 24-bit frame, carrying miso_bit and the converted flag.
// Select and deselect beats, and ignored clocks, give no output beat.
// i_cfg_we / i_cfg_data write the reference voltage; write only while idle.
// An accepted beat lands in the output register in the cycle after it is taken.
// One beat per cycle while the output register has room, except the clock beat that
// decodes a single-ended request below full scale, which starts the restoring divider:
// it produces one quotient bit a cycle, and the input stalls until all 12 bits are done.
// A stalled receiver holds the output register; a new beat is taken only in
// the cycle the register empties or is being taken.
// Reset (synchronous, active low) deselects, rewinds the frame counters,
// clears command and reply and loads a reference of 3300 mV.
`default_nettype none
module spi_adc_12bit_bit_serial_frame_top
    import sabsf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in_beat          i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_beat              o_out,
    input  wire logic              i_cfg_we,
    input  wire logic [VOLT_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    sabsf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sabsf_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none
module tb;
    import sabsf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT        = 400000;
    localparam int DRAIN_CYCLES = 32;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_EDGES  = 340;
    localparam int NUM_PHASES   = 5;
    localparam int DIR_ROWS     = 29;
    localparam logic [RESULT_BITS-1:0] FULL_CODE = '1;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_beat              i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_beat             o_out;
    logic                  i_cfg_we    = 1'b0;
    logic [VOLT_W-1:0]     i_cfg_data  = '0;

    spi_adc_12bit_bit_serial_frame_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // shadow of the converter state
    logic [VOLT_W-1:0]      vref_q     = REF_RESET;
    logic                   sel_q      = 1'b0;
    logic [1:0]             byte_cnt   = BYTE_FIRST;
    logic [2:0]             bit_pos    = POS_MSB;
    logic [7:0]             cmd_byte [2] = '{8'h00, 8'h00};
    logic [RESULT_BITS-1:0] reply_code = '0;

    t_out_beat expected_bits [$];
    int        mismatches = 0;
    int        edges_done = 0;
    int        cycle_cnt  = 0;
    int        quiet_left = 0;
    logic      idle_on    = 1'b1;
    logic      hold_req   = 1'b0;
    logic      hold_taken = 1'b0;

    typedef struct packed {
        logic [1:0]        kind;
        logic              mosi;
        logic [VOLT_W-1:0] volt;
        logic              typed;
        logic              has;
        logic              miso;
        logic              conv;
    } t_dir_row;

    // one full-scale frame on channel 7 at the reset reference, plus framing corner cases
    t_dir_row script [DIR_ROWS] = '{
        '{KIND_CLOCK,    1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
        '{KIND_SELECT,   1'b0, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
        '{KIND_SELECT,   1'b1, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b1},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b0, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b0},
        '{KIND_CLOCK,    1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0},
        '{KIND_DESELECT, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b0}
    };

    function automatic logic [RESULT_BITS-1:0] to_code(input logic [VOLT_W-1:0] mv);
        logic [VOLT_W+RESULT_BITS-1:0] q;
        if (vref_q == '0) return FULL_CODE;
        q = {mv, {RESULT_BITS{1'b0}}} / vref_q;
        if (q > FULL_CODE) return FULL_CODE;
        return q[RESULT_BITS-1:0];
    endfunction

    // advances the converter shadow by one beat, returns the serial edge it yields
    task automatic adc_serial_step(input t_in_beat b, output bit got, output t_out_beat r);
        logic [2:0]        pos;
        logic [2:0]        chan;
        logic [WORD_W-1:0] word;
        logic [7:0]        rbyte;
        logic [VOLT_W-1:0] mv;
        got = 1'b0;
        r   = '0;
        case (b.kind)
            KIND_SELECT: begin
                if (!sel_q) begin
                    byte_cnt = BYTE_FIRST;
                    bit_pos  = POS_MSB;
                end
                sel_q = 1'b1;
            end
            KIND_DESELECT: sel_q = 1'b0;
            KIND_CLOCK: begin
                if (sel_q && byte_cnt != BYTE_DONE) begin
                    pos = bit_pos;
                    if (pos == POS_MSB) begin
                        if (byte_cnt != BYTE_LAST) cmd_byte[byte_cnt[0]] = '0;
                        if (byte_cnt == BYTE_FIRST) reply_code = '0;
                    end
                    if (byte_cnt != BYTE_LAST && b.mosi_bit)
                        cmd_byte[byte_cnt[0]][pos] = 1'b1;
                    // miso comes from the reply as it stood before this edge's decode
                    word = WORD_W'(reply_code);
                    case (byte_cnt)
                        BYTE_CMD:  rbyte = word[15:8];
                        BYTE_LAST: rbyte = word[7:0];
                        default:   rbyte = '0;
                    endcase
                    r.miso_bit = rbyte[pos];
                    if (byte_cnt == BYTE_CMD && pos == POS_DECODE &&
                        cmd_byte[0][CMD_START_BIT]) begin
                        r.converted = 1'b1;
                        if (cmd_byte[0][CMD_SGL_BIT]) begin
                            chan = {cmd_byte[0][CMD_CH_MSB], cmd_byte[1][7:6]};
                            case (chan)
                                3'd0:    mv = b.ch0_voltage;
                                3'd1:    mv = b.ch1_voltage;
                                3'd2:    mv = b.ch2_voltage;
                                3'd3:    mv = b.ch3_voltage;
                                3'd4:    mv = b.ch4_voltage;
                                3'd5:    mv = b.ch5_voltage;
                                3'd6:    mv = b.ch6_voltage;
                                default: mv = b.ch7_voltage;
                            endcase
                            reply_code = to_code(mv);
                        end else begin
                            reply_code = '0;
                        end
                    end
                    if (pos == POS_LSB) begin
                        bit_pos  = POS_MSB;
                        byte_cnt = byte_cnt + 2'd1;
                    end else begin
                        bit_pos = pos - 3'd1;
                    end
                    got = 1'b1;
                end
            end
            default: ;
        endcase
    endtask

    // offers one beat, waits for the handshake, then records what it should yield
    task automatic push_beat(input t_in_beat b, input bit typed, input bit has,
                             input t_out_beat typed_val);
        bit        got;
        t_out_beat r;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in       <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        adc_serial_step(b, got, r);
        if (typed) begin
            got = has;
            r   = typed_val;
        end
        if (got) begin
            expected_bits.push_back(r);
            edges_done++;
        end
    endtask

    function automatic logic [VOLT_W-1:0] pick_volt();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 32'hFFFF;
            // straddle the full-scale threshold
            2, 3: v = ((32'(vref_q) * 32'(FULL_CODE)) >> RESULT_BITS) + $urandom_range(0, 3);
            4: v = $urandom_range(0, 65535);
            default: v = $urandom_range(0, (32'(vref_q) * 5) / 4);
        endcase
        if (v > 32'hFFFF) v = 32'hFFFF;
        return v[VOLT_W-1:0];
    endfunction

    function automatic t_in_beat make_beat(input logic [1:0] kind, input logic mosi);
        t_in_beat b;
        b.kind        = kind;
        b.mosi_bit    = mosi;
        b.ch0_voltage = pick_volt();
        b.ch1_voltage = pick_volt();
        b.ch2_voltage = pick_volt();
        b.ch3_voltage = pick_volt();
        b.ch4_voltage = pick_volt();
        b.ch5_voltage = pick_volt();
        b.ch6_voltage = pick_volt();
        b.ch7_voltage = pick_volt();
        return b;
    endfunction

    task automatic send_rand(input logic [1:0] kind, input logic mosi);
        push_beat(make_beat(kind, mosi), 1'b0, 1'b0, '0);
    endtask

    task automatic random_frame();
        logic [7:0]  cmd0;
        logic [23:0] bits;
        int          n_clk;
        int          pick;
        cmd0 = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 7));
        cmd0[CMD_START_BIT] = ($urandom_range(0, 7) != 0);
        cmd0[CMD_SGL_BIT]   = ($urandom_range(0, 3) != 0);
        bits = {cmd0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        // stray beats now and then, which may leave a frame half open
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
                send_rand(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            n_clk = $urandom_range(1, 23);
        else if (pick == 1)
            n_clk = 24 + $urandom_range(1, 3);
        else
            n_clk = 24;
        send_rand(KIND_SELECT, 1'($urandom_range(0, 1)));
        for (int i = 0; i < n_clk; i++) begin
            if ($urandom_range(0, 63) == 0) send_rand(KIND_SELECT, 1'b0);
            send_rand(KIND_CLOCK, (i < 24) ? bits[23-i] : 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 9) != 0) send_rand(KIND_DESELECT, 1'($urandom_range(0, 1)));
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_bits.size() != 0) @(posedge i_clk);
        // dropped beats give no output, so leave room for a divide still in flight
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vref(input logic [VOLT_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        vref_q = v;
    endtask

    task automatic check_beat(input t_out_beat got);
        t_out_beat want;
        if (expected_bits.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected output beat: miso %0b conv %0b",
                         got.miso_bit, got.converted);
            mismatches++;
        end else begin
            want = expected_bits.pop_front();
            if (got.miso_bit !== want.miso_bit || got.converted !== want.converted) begin
                if (mismatches < 10)
                    $display("beat mismatch: expected miso %0b conv %0b, got miso %0b conv %0b",
                             want.miso_bit, want.converted, got.miso_bit, got.converted);
                mismatches++;
            end
        end
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (o_out_valid === 1'b1 && i_out_ready) check_beat(o_out);
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            quiet_left = HOLD_CYCLES;
        end else if (quiet_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
            quiet_left = $urandom_range(1, 8);
        end
        if (quiet_left != 0) begin
            quiet_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        t_in_beat        b;
        int              target;
        logic [VOLT_W-1:0] vref_plan [NUM_PHASES];
        vref_plan = '{16'd1, 16'hFFFF, 16'd4096, 16'd0, REF_RESET};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            b.kind     = script[i].kind;
            b.mosi_bit = script[i].mosi;
            {b.ch0_voltage, b.ch1_voltage, b.ch2_voltage, b.ch3_voltage,
             b.ch4_voltage, b.ch5_voltage, b.ch6_voltage, b.ch7_voltage} = {8{script[i].volt}};
            push_beat(b, script[i].typed, script[i].has,
                      t_out_beat'({script[i].miso, script[i].conv}));
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            set_vref((vref_plan[p] == '0) ? VOLT_W'($urandom_range(1, 65535)) : vref_plan[p]);
            if (p == NUM_PHASES - 1) idle_on <= 1'b0;
            if (p == 2) hold_req <= 1'b1;
            target = edges_done + PHASE_EDGES;
            while (edges_done < target) random_frame();
        end

        settle();
        mismatches += expected_bits.size();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
`default_nettype wire
